// File: hdl/vtcv_pkg.sv
// ----------------------------------------------------------------------------
// vtcv_pkg
// Shared types, codes and helpers for the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtcv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_DEPTH    = 28;
  localparam int MV_BASE       = 0;
  localparam int PR_BASE       = 12;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  // Input item commands
  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VP_X0     = 8'd0,
    REG_VP_Y0     = 8'd1,
    REG_VP_WIDTH  = 8'd2,
    REG_VP_HEIGHT = 8'd3
  } cfg_reg_t;

  // Clip-space coordinates handed from the matrix stages to the divide
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } clip_vec_t;

  // Cycles from the divider's input to its output register
  function automatic int div_latency(input int frac_bits);
    div_latency = 32 + frac_bits + 2;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat_q(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    sat_q = r;
  endfunction

endpackage

// File: hdl/vtcv_matrix.sv
// ----------------------------------------------------------------------------
// vtcv_matrix
// Coefficient store plus modelview and projection transforms, four stages:
// modelview products, eye sums, projection products, clip sums.
// ----------------------------------------------------------------------------
module vtcv_matrix #(
  parameter int FRAC_BITS = vtcv_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vert_take,
  input  logic signed [31:0]        vert_x,
  input  logic signed [31:0]        vert_y,
  input  logic signed [31:0]        vert_z,
  input  logic                      load_take,
  input  logic [4:0]                load_index,
  input  logic signed [31:0]        load_value,
  output logic                      busy,
  output logic                      clip_valid,
  output vtcv_pkg::clip_vec_t       clip
);

  logic signed [31:0] coef [vtcv_pkg::COEF_DEPTH];
  logic signed [31:0] obj  [3];
  logic signed [63:0] p_mv [9];
  logic signed [31:0] eye  [3];
  logic signed [63:0] p_pr [12];
  logic               v1, v2, v3;

  assign obj[0] = vert_x;
  assign obj[1] = vert_y;
  assign obj[2] = vert_z;

  // Coefficients are only rewritten while no vertex still reads them
  assign busy = v1 | v2 | v3;

  // Coefficient store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtcv_pkg::COEF_DEPTH; i++) coef[i] <= '0;
    end else if (load_take && (load_index < 5'(vtcv_pkg::COEF_DEPTH))) begin
      coef[load_index] <= load_value;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      clip_valid <= 1'b0;
    end else if (en) begin
      v1 <= vert_take;
      v2 <= v1;
      v3 <= v2;
      clip_valid <= v3;
    end
  end

  // Stage 1: modelview products, column-major coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_mv[r*3+c] <= coef[vtcv_pkg::MV_BASE + c*3 + r] * obj[c];
        end
      end
    end
  end

  // Stage 2: eye coordinates, floor to the fraction then translate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        eye[r] <= vtcv_pkg::sat_q(
          ((72'(p_mv[r*3]) + 72'(p_mv[r*3+1]) + 72'(p_mv[r*3+2])) >>> FRAC_BITS)
          + 72'(coef[vtcv_pkg::MV_BASE + 9 + r]));
      end
    end
  end

  // Stage 3: projection products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_pr[r*3+c] <= coef[vtcv_pkg::PR_BASE + c*4 + r] * eye[c];
        end
      end
    end
  end

  // Stage 4: clip coordinates
  always_ff @(posedge clk) begin
    if (en) begin
      clip.x <= vtcv_pkg::sat_q(((72'(p_pr[0]) + 72'(p_pr[1]) + 72'(p_pr[2])) >>> FRAC_BITS)
                + 72'(coef[vtcv_pkg::PR_BASE + 12]));
      clip.y <= vtcv_pkg::sat_q(((72'(p_pr[3]) + 72'(p_pr[4]) + 72'(p_pr[5])) >>> FRAC_BITS)
                + 72'(coef[vtcv_pkg::PR_BASE + 13]));
      clip.z <= vtcv_pkg::sat_q(((72'(p_pr[6]) + 72'(p_pr[7]) + 72'(p_pr[8])) >>> FRAC_BITS)
                + 72'(coef[vtcv_pkg::PR_BASE + 14]));
      clip.w <= vtcv_pkg::sat_q(((72'(p_pr[9]) + 72'(p_pr[10]) + 72'(p_pr[11])) >>> FRAC_BITS)
                + 72'(coef[vtcv_pkg::PR_BASE + 15]));
    end
  end

endmodule

// File: hdl/vtcv_divider.sv
// ----------------------------------------------------------------------------
// vtcv_divider
// Pipelined signed fixed-point divide, one quotient bit per stage.
// Rounds toward zero and saturates; a zero divisor saturates by the sign of
// the numerator, and gives zero for a zero numerator.
// ----------------------------------------------------------------------------
module vtcv_divider #(
  parameter int FRAC_BITS = vtcv_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo,
  output logic               den_zero
);

  localparam int QW = 32 + FRAC_BITS;

  logic [31:0]    rem  [QW+1];
  logic [QW-1:0]  dvd  [QW+1];
  logic [QW-1:0]  qacc [QW+1];
  logic [31:0]    dmag [QW+1];
  logic           neg  [QW+1];
  logic           dz   [QW+1];
  logic           nneg [QW+1];
  logic           nzer [QW+1];
  logic [QW-1:0]  q_fin;

  // Setup: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      dvd[0]  <= {(num[31] ? (~num + 32'd1) : num), {FRAC_BITS{1'b0}}};
      qacc[0] <= '0;
      dmag[0] <= den[31] ? (~den + 32'd1) : den;
      neg[0]  <= num[31] ^ den[31];
      dz[0]   <= (den == '0);
      nneg[0] <= num[31];
      nzer[0] <= (num == '0);
    end
  end

  // Restoring steps
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [32:0] trial;
    logic        take;
    assign trial = {rem[k-1], dvd[k-1][QW-1]};
    assign take  = (trial >= {1'b0, dmag[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? 32'(trial - {1'b0, dmag[k-1]}) : trial[31:0];
        dvd[k]  <= {dvd[k-1][QW-2:0], 1'b0};
        qacc[k] <= {qacc[k-1][QW-2:0], take};
        dmag[k] <= dmag[k-1];
        neg[k]  <= neg[k-1];
        dz[k]   <= dz[k-1];
        nneg[k] <= nneg[k-1];
        nzer[k] <= nzer[k-1];
      end
    end
  end

  assign q_fin = qacc[QW];

  // Sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      den_zero <= dz[QW];
      if (dz[QW]) begin
        quo <= nzer[QW] ? 32'sh0 : (nneg[QW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
      end else if (neg[QW]) begin
        quo <= (q_fin > QW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-q_fin);
      end else begin
        quo <= (q_fin > QW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(q_fin);
      end
    end
  end

endmodule

// File: hdl/vtcv_viewport.sv
// ----------------------------------------------------------------------------
// vtcv_viewport
// Clip test and viewport mapping, two stages; the second is the output
// register.
// ----------------------------------------------------------------------------
module vtcv_viewport #(
  parameter int FRAC_BITS = vtcv_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               ndc_valid,
  input  logic signed [31:0] ndc_x,
  input  logic signed [31:0] ndc_y,
  input  logic signed [31:0] ndc_z,
  input  logic               w_zero,
  input  logic [11:0]        vp_x0,
  input  logic [11:0]        vp_y0,
  input  logic [12:0]        vp_width,
  input  logic [12:0]        vp_height,
  output logic               out_valid,
  output logic signed [31:0] pixel_x,
  output logic signed [31:0] pixel_y,
  output logic signed [31:0] depth,
  output logic               clipped
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic               va;
  logic signed [47:0] prod_x, prod_y;
  logic signed [31:0] z_a;
  logic               clip_a;
  logic signed [33:0] sx, sy;

  assign sx = 34'(ndc_x) + 34'(ONE);
  assign sy = 34'(ndc_y) + 34'(ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= ndc_valid;
      out_valid <= va;
    end
  end

  // Stage A: scale by viewport size, unit cube test
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= sx * $signed({1'b0, vp_width});
      prod_y <= sy * $signed({1'b0, vp_height});
      z_a    <= ndc_z;
      clip_a <= w_zero || (ndc_x < -ONE) || (ndc_x > ONE) || (ndc_y < -ONE) ||
                (ndc_y > ONE) || (ndc_z < -ONE) || (ndc_z > ONE);
    end
  end

  // Stage B: halve, add offset, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      pixel_x <= vtcv_pkg::sat_q($signed(72'(vp_x0) << FRAC_BITS) + 72'(prod_x >>> 1));
      pixel_y <= vtcv_pkg::sat_q($signed(72'(vp_y0) << FRAC_BITS) + 72'(prod_y >>> 1));
      depth   <= z_a;
      clipped <= clip_a;
    end
  end

endmodule

// File: hdl/vertex_transform_clip_viewport.sv
// ----------------------------------------------------------------------------
// vertex_transform_clip_viewport
// Vertex transform, perspective divide and viewport mapping.
// ----------------------------------------------------------------------------
// One item per clock while results are taken and no load is held off. A vertex
// item passes through the four matrix stages, the bit-per-stage divider, and
// the two viewport stages.
// A coefficient load item is held off while a vertex is in the first three
// matrix stages.
// The whole pipeline stalls as one when a result is not taken.
module vertex_transform_clip_viewport #(
  parameter int FRAC_BITS = vtcv_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [4:0]                       coef_index,
  input  logic signed [31:0]               coef_value,
  input  logic signed [31:0]               vert_x,
  input  logic signed [31:0]               vert_y,
  input  logic signed [31:0]               vert_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               pixel_x,
  output logic signed [31:0]               pixel_y,
  output logic signed [31:0]               depth,
  output logic                             clipped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vtcv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtcv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIV_LAT = vtcv_pkg::div_latency(FRAC_BITS);

  logic                en;
  logic                busy;
  logic                take;
  logic                clip_valid;
  vtcv_pkg::clip_vec_t clip;
  logic [DIV_LAT-1:0]  dvalid;
  logic signed [31:0]  ndc_x, ndc_y, ndc_z;
  logic                w_zero;
  logic                wz_x, wz_y, wz_z;
  logic [11:0]         vp_x0, vp_y0;
  logic [12:0]         vp_width, vp_height;

  // Pipeline advances unless a result is stuck at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en && ((vtcv_pkg::cmd_t'(cmd) == vtcv_pkg::CMD_VERTEX) || !busy);
  assign take     = in_valid && in_ready;

  // Viewport registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_x0     <= '0;
      vp_y0     <= '0;
      vp_width  <= '0;
      vp_height <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vtcv_pkg::REG_VP_X0:     vp_x0     <= cfg_data[11:0];
        vtcv_pkg::REG_VP_Y0:     vp_y0     <= cfg_data[11:0];
        vtcv_pkg::REG_VP_WIDTH:  vp_width  <= cfg_data[12:0];
        vtcv_pkg::REG_VP_HEIGHT: vp_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  vtcv_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .vert_take  (take && (vtcv_pkg::cmd_t'(cmd) == vtcv_pkg::CMD_VERTEX)),
    .vert_x     (vert_x),
    .vert_y     (vert_y),
    .vert_z     (vert_z),
    .load_take  (take && (vtcv_pkg::cmd_t'(cmd) == vtcv_pkg::CMD_LOAD)),
    .load_index (coef_index),
    .load_value (coef_value),
    .busy       (busy),
    .clip_valid (clip_valid),
    .clip       (clip)
  );

  // Valid bits alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
    end else if (en) begin
      dvalid <= {dvalid[DIV_LAT-2:0], clip_valid};
    end
  end

  vtcv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk), .en (en), .num (clip.x), .den (clip.w),
    .quo (ndc_x), .den_zero (wz_x)
  );

  vtcv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk), .en (en), .num (clip.y), .den (clip.w),
    .quo (ndc_y), .den_zero (wz_y)
  );

  vtcv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk (clk), .en (en), .num (clip.z), .den (clip.w),
    .quo (ndc_z), .den_zero (wz_z)
  );

  // All three dividers share the divisor, so their flags agree
  assign w_zero = wz_x | wz_y | wz_z;

  vtcv_viewport #(.FRAC_BITS(FRAC_BITS)) u_viewport (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ndc_valid (dvalid[DIV_LAT-1]),
    .ndc_x     (ndc_x),
    .ndc_y     (ndc_y),
    .ndc_z     (ndc_z),
    .w_zero    (w_zero),
    .vp_x0     (vp_x0),
    .vp_y0     (vp_y0),
    .vp_width  (vp_width),
    .vp_height (vp_height),
    .out_valid (out_valid),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .depth     (depth),
    .clipped   (clipped)
  );

endmodule

// File: hdl/vtcv_checker.sv
// ----------------------------------------------------------------------------
// vtcv_assert
// Port-level checks for the vertex transform block.
// ----------------------------------------------------------------------------
module vtcv_assert (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pixel_x,
  input logic signed [31:0] pixel_y,
  input logic signed [31:0] depth,
  input logic               clipped,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
                                $stable(depth) && $stable(clipped))
    else $error("result changed while stalled");

  // Pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A stuck output stalls the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while output stalled");

  // Register writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind vertex_transform_clip_viewport vtcv_assert u_vtcv_assert (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pixel_x   (pixel_x),
  .pixel_y   (pixel_y),
  .depth     (depth),
  .clipped   (clipped),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// File: verif/vtcv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vtcv_checker
// Watches the input, result and register channels of the vertex pipeline,
// predicts each vertex result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module vtcv_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic [4:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] vert_x,
  input  logic signed [31:0] vert_y,
  input  logic signed [31:0] vert_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] pixel_x,
  input  logic signed [31:0] pixel_y,
  input  logic signed [31:0] depth,
  input  logic               clipped,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int FB = vtcv_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dz;
    logic               clip;
  } vtx_result_t;

  logic signed [31:0] coefs [vtcv_pkg::COEF_DEPTH];
  logic [11:0] vp_x0, vp_y0;
  logic [12:0] vp_w, vp_h;
  vtx_result_t result_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor of v / 2^s
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  // three-term fixed point dot product plus offset, floor rounded
  function automatic longint mac3(input longint a0, a1, a2, v0, v1, v2, t);
    longint hi, lo, p;
    longint msk;
    msk = (64'sd1 <<< FB) - 1;
    hi = 0; lo = 0;
    p = a0 * v0; hi += floor_shr(p, FB); lo += p & msk;
    p = a1 * v1; hi += floor_shr(p, FB); lo += p & msk;
    p = a2 * v2; hi += floor_shr(p, FB); lo += p & msk;
    return clamp32(hi + floor_shr(lo, FB) + t);
  endfunction

  function automatic longint ndc_div(input longint num, input longint den);
    if (den == 0) return (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
    return clamp32((num * (64'sd1 <<< FB)) / den);
  endfunction

  function automatic longint window_map(input longint n, input longint off,
                                        input longint sz);
    longint one;
    one = 64'sd1 <<< FB;
    return clamp32(off * one + floor_shr((one + n) * sz, 1));
  endfunction

  function automatic vtx_result_t transform_vertex(input longint ox, oy, oz);
    longint eye[3], clp[4], ndc[3], one;
    vtx_result_t r;
    one = 64'sd1 <<< FB;
    for (int i = 0; i < 3; i++)
      eye[i] = mac3(coefs[vtcv_pkg::MV_BASE+i], coefs[vtcv_pkg::MV_BASE+3+i],
                    coefs[vtcv_pkg::MV_BASE+6+i], ox, oy, oz,
                    coefs[vtcv_pkg::MV_BASE+9+i]);
    for (int i = 0; i < 4; i++)
      clp[i] = mac3(coefs[vtcv_pkg::PR_BASE+i], coefs[vtcv_pkg::PR_BASE+4+i],
                    coefs[vtcv_pkg::PR_BASE+8+i], eye[0], eye[1], eye[2],
                    coefs[vtcv_pkg::PR_BASE+12+i]);
    r.clip = (clp[3] == 0);
    for (int i = 0; i < 3; i++) begin
      ndc[i] = ndc_div(clp[i], clp[3]);
      if (ndc[i] < -one || ndc[i] > one) r.clip = 1'b1;
    end
    r.px = window_map(ndc[0], vp_x0, vp_w);
    r.py = window_map(ndc[1], vp_y0, vp_h);
    r.dz = ndc[2];
    return r;
  endfunction

  // track state and predict on accepted items
  always @(posedge clk) begin
    vtx_result_t got, exp_r;
    if (rst) begin
      for (int i = 0; i < vtcv_pkg::COEF_DEPTH; i++) coefs[i] = '0;
      vp_x0 = '0; vp_y0 = '0; vp_w = '0; vp_h = '0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (vtcv_pkg::cfg_reg_t'(cfg_index))
          vtcv_pkg::REG_VP_X0:     vp_x0 = cfg_data[11:0];
          vtcv_pkg::REG_VP_Y0:     vp_y0 = cfg_data[11:0];
          vtcv_pkg::REG_VP_WIDTH:  vp_w  = cfg_data[12:0];
          vtcv_pkg::REG_VP_HEIGHT: vp_h  = cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{pixel_x, pixel_y, depth, clipped};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result px=%h py=%h z=%h c=%b", $time,
                   pixel_x, pixel_y, depth, clipped);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (got.px !== exp_r.px) begin
            $display("%0t: pixel_x exp %h got %h", $time, exp_r.px, got.px);
            fail_count++;
          end
          if (got.py !== exp_r.py) begin
            $display("%0t: pixel_y exp %h got %h", $time, exp_r.py, got.py);
            fail_count++;
          end
          if (got.dz !== exp_r.dz) begin
            $display("%0t: depth exp %h got %h", $time, exp_r.dz, got.dz);
            fail_count++;
          end
          if (got.clip !== exp_r.clip) begin
            $display("%0t: clipped exp %b got %b", $time, exp_r.clip, got.clip);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == vtcv_pkg::CMD_LOAD) begin
          if (coef_index < vtcv_pkg::COEF_DEPTH) coefs[coef_index] = coef_value;
        end else begin
          result_q.insert(result_q.size(), transform_vertex(vert_x, vert_y, vert_z));
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// File: verif/tb_vertex_transform_clip_viewport.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_clip_viewport
// Drives coefficient loads, vertices and viewport settings with random
// gaps and output stalls; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_vertex_transform_clip_viewport;

  localparam int LATENCY  = 4 + vtcv_pkg::div_latency(vtcv_pkg::FRAC_BITS_DEF) + 2;
  localparam int WDOG_MAX = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic cmd = vtcv_pkg::CMD_VERTEX;
  logic [4:0] coef_index = '0;
  logic signed [31:0] coef_value = '0, vert_x = '0, vert_y = '0, vert_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] pixel_x, pixel_y, depth;
  logic clipped;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_transform_clip_viewport DUT (.*);

  vtcv_checker u_checker (.*);

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls; one long hold-off when requested
  always @(posedge clk) begin
    int n;
    if (!rst) begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      out_ready <= 1'b1;
      n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (n > 0) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_item(input vtcv_pkg::cmd_t c, input logic [4:0] idx,
                           input logic [31:0] val,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c; coef_index <= idx; coef_value <= val;
    vert_x <= x; vert_y <= y; vert_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_coef(input int idx, input logic [31:0] val);
    send_item(vtcv_pkg::CMD_LOAD, 5'(idx), val, $urandom, $urandom, $urandom, 1'b0);
  endtask

  task automatic send_vertex(input logic [31:0] x, y, z, input bit no_gap);
    send_item(vtcv_pkg::CMD_VERTEX, 5'($urandom), $urandom, x, y, z, no_gap);
  endtask

  task automatic end_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // valid stays up across back-to-back writes; the caller drops it
  task automatic write_reg(input vtcv_pkg::cfg_reg_t r, input logic [15:0] d);
    cfg_valid <= 1'b1; cfg_index <= r; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_viewport(input logic [15:0] x0, y0, w, h);
    write_reg(vtcv_pkg::REG_VP_X0, x0);
    write_reg(vtcv_pkg::REG_VP_Y0, y0);
    write_reg(vtcv_pkg::REG_VP_WIDTH, w);
    write_reg(vtcv_pkg::REG_VP_HEIGHT, h);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // small coefficient near an identity-like value, or a full random one
  function automatic logic [31:0] rand_coef(input bit diag);
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (diag) return 32'sd65536 + $signed($urandom_range(0, 65535)) - 32'sd32768;
    return $signed($urandom_range(0, 32767)) - 32'sd16384;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 262143)) - 32'sd131072;
  endfunction

  // a full matrix set: modelview near identity, projection with w = -z + c
  task automatic load_matrices();
    for (int i = 0; i < 12; i++)
      load_coef(vtcv_pkg::MV_BASE + i, rand_coef(i == 0 || i == 4 || i == 8));
    for (int i = 0; i < 16; i++) begin
      if (i == 11) load_coef(vtcv_pkg::PR_BASE + i, 32'hFFFF_0000);
      else if (i == 15) load_coef(vtcv_pkg::PR_BASE + i, $urandom_range(0, 6) << 16);
      else if (i == 3 || i == 7) load_coef(vtcv_pkg::PR_BASE + i, 32'd0);
      else load_coef(vtcv_pkg::PR_BASE + i, rand_coef(i == 0 || i == 5 || i == 10));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes on a zero matrix (zero w) and an identity
    set_viewport(16'd0, 16'd0, 16'd0, 16'd0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    for (int i = 0; i < 28; i++)
      if (i == 0 || i == 4 || i == 8 || i == 12 || i == 17 || i == 22 || i == 27)
        load_coef(i, 32'h0001_0000);
    load_coef(31, 32'hFFFF_FFFF);
    send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0, 1'b0);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0);
    load_coef(27, 32'h0);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0);
    load_coef(27, 32'h8000_0000);
    send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b0);
    load_coef(27, 32'h7FFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    end_input();
    drain();

    // extremes of the viewport
    set_viewport(16'hFFFF, 16'hFFFF, 16'd4096, 16'd4096);
    load_coef(27, 32'h0001_0000);
    send_vertex(32'h0000_FFFF, 32'hFFFF_0001, 32'h0, 1'b0);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    end_input();
    drain();
    set_viewport(16'd0, 16'd0, 16'd8191, 16'd8191);

    // random phases, each with a new matrix set and viewport
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0)
        set_viewport(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                     16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)));
      load_matrices();
      for (int k = 0; k < 40; k++) begin
        if (ph == 3 && k == 5) long_hold = 1'b1;
        if ($urandom_range(0, 19) == 0)
          load_coef($urandom_range(0, 31), rand_coef(1'b0));
        else
          send_vertex(rand_coord(), rand_coord(), rand_coord(), (ph == 3));
      end
      end_input();
      drain();
    end
    set_viewport(16'd0, 16'd0, 16'd0, 16'd0);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
